/* hdl/tsc_pkg.sv */
// tsc_pkg: shared types and constants of the cycle-counter timestamp clock.
// Used by the channel interfaces and by every tsc module; depends on nothing.

package tsc_pkg;

  // Query kinds carried with every input word
  typedef enum logic [1:0] {
    KIND_SYNC  = 2'd0,
    KIND_RT_NS = 2'd1,
    KIND_RT_US = 2'd2,
    KIND_MONO  = 2'd3
  } kind_e;

  // Field widths
  localparam int unsigned CycW  = 64;
  localparam int unsigned SysW  = 63;
  localparam int unsigned TimeW = 64;
  localparam int unsigned SecW  = 35;
  localparam int unsigned SubW  = 30;
  localparam int unsigned RegW  = 32;

  // Register reset values
  localparam logic [RegW-1:0] ScaleReset  = 32'd134217728;
  localparam logic [RegW-1:0] ResyncReset = 32'd1000000;

  // Fixed-point cycle conversion: hi*scale << 5, lo*scale >> 27
  localparam int unsigned ScaleShift = 5;
  localparam int unsigned LoShift    = RegW - ScaleShift;

  // Seconds split: 1e9 = 2^9 * 5^9, so t/1e9 = (t >> 9) / 5^9.
  // SecRecip = floor(2^55 / 5^9) = floor(2^64 / 1e9); the estimate is low by at most one.
  localparam logic [SubW-1:0] NsPerSec      = 30'd1000000000;
  localparam int unsigned     SecPreShift   = 9;
  localparam logic [SecW-1:0] SecRecip      = 35'd18446744073;
  localparam int unsigned     SecRecipShift = 55;

  // Microseconds: r/1000 = (r >> 3) / 125, exact with ceil(2^34 / 125) for r < 2^30
  localparam int unsigned UsPreShift   = 3;
  localparam int unsigned UsRecipW     = 28;
  localparam logic [UsRecipW-1:0] UsRecip = 28'd137438954;
  localparam int unsigned UsRecipShift = 34;

  // One accepted query
  typedef struct packed {
    kind_e            kind;
    logic [CycW-1:0]  cycle_count;
    logic [SysW-1:0]  sys_time_ns;
  } item_t;

  // Conversion stage to split stage: either the system time or base plus delta
  typedef struct packed {
    logic              sel_sys;
    logic [SysW-1:0]   sys_time_ns;
    logic [TimeW-1:0]  base_time_ns;
    logic [TimeW-1:0]  delta_ns;
    logic              micro;
  } conv_t;

  // One result word
  typedef struct packed {
    logic [SecW-1:0] seconds;
    logic [SubW-1:0] subsecond;
    logic            resynced;
  } result_t;

endpackage

/* hdl/tsc_in_if.sv */
// tsc_in_if: valid/ready channel carrying one timestamp query.
// Depends on tsc_pkg for field widths and the kind type.

interface tsc_in_if;
  import tsc_pkg::*;

  logic                 valid;
  logic                 ready;
  kind_e                kind;
  logic [CycW-1:0]      cycle_count;
  logic [SysW-1:0]      sys_time_ns;

  modport source (output valid, kind, cycle_count, sys_time_ns, input ready);
  modport sink   (input valid, kind, cycle_count, sys_time_ns, output ready);
endinterface

/* hdl/tsc_out_if.sv */
// tsc_out_if: valid/ready channel carrying one timestamp result.
// Depends on tsc_pkg for field widths.

interface tsc_out_if;
  import tsc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SecW-1:0]      seconds;
  logic [SubW-1:0]      subsecond;
  logic                 resynced;

  modport source (output valid, seconds, subsecond, resynced, input ready);
  modport sink   (input valid, seconds, subsecond, resynced, output ready);
endinterface

/* hdl/tsc_convert.sv */
// tsc_base_conv: input register, counter delta, fixed-point conversion and resync decision.
// Holds the base state; resolves in-flight reloads by computing deltas against each
// candidate base. Depends on tsc_pkg.

module tsc_base_conv (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           in_valid_i,
  input  tsc_pkg::item_t in_item_i,
  input  logic [31:0]    cycle_scale_i,
  input  logic [31:0]    resync_ns_i,
  output logic           conv_valid_o,
  output tsc_pkg::conv_t conv_o
);
  import tsc_pkg::*;

  // Candidate bases: committed base, word one ahead, word two ahead
  localparam int unsigned NumCand = 3;

  // Stage 1: accepted word
  item_t               r1_q;
  logic                r1_valid_q;
  // Stage 2: deltas in cycles
  item_t               r2_q;
  logic                r2_valid_q;
  logic [CycW-1:0]     diff_d [NumCand];
  logic [CycW-1:0]     diff_q [NumCand];
  // Stage 3: partial products
  item_t               r3_q;
  logic                r3_valid_q;
  logic [TimeW-1:0]    ph_d [NumCand];
  logic [TimeW-1:0]    ph_q [NumCand];
  logic [TimeW-1:0]    pl_d [NumCand];
  logic [TimeW-1:0]    pl_q [NumCand];
  // Base state and reload history
  logic [CycW-1:0]     base_cyc_q;
  logic [TimeW-1:0]    base_time_q;
  logic                rs1_q;
  logic                rs2_q;

  logic [CycW-1:0]     base0;
  logic [TimeW-1:0]    ns [NumCand];
  logic [1:0]          sel;
  logic [TimeW-1:0]    delta;
  logic                is_mono;
  logic                resync;

  // Deltas against every base this word may end up with
  always_comb begin
    base0     = (r1_q.kind == KIND_MONO) ? '0 : base_cyc_q;
    diff_d[0] = r1_q.cycle_count - base0;
    diff_d[1] = r1_q.cycle_count - r2_q.cycle_count;
    diff_d[2] = r1_q.cycle_count - r3_q.cycle_count;
  end

  // Word products of each delta with the scale
  always_comb begin
    for (int i = 0; i < NumCand; i++) begin
      ph_d[i] = 64'(diff_q[i][CycW-1:RegW]) * 64'(cycle_scale_i);
      pl_d[i] = 64'(diff_q[i][RegW-1:0]) * 64'(cycle_scale_i);
    end
  end

  // Scaled sums, base choice and reload decision
  always_comb begin
    for (int i = 0; i < NumCand; i++) begin
      ns[i] = (ph_q[i] << ScaleShift) + (pl_q[i] >> LoShift);
    end
    is_mono = (r3_q.kind == KIND_MONO);
    priority if (is_mono) begin
      sel = 2'd0;
    end else if (rs1_q) begin
      sel = 2'd1;
    end else if (rs2_q) begin
      sel = 2'd2;
    end else begin
      sel = 2'd0;
    end
    delta  = ns[sel];
    resync = r3_valid_q &&
             ((r3_q.kind == KIND_SYNC) ||
              (!is_mono && (delta >= 64'(resync_ns_i))));

    conv_valid_o        = r3_valid_q;
    conv_o.sel_sys      = resync;
    conv_o.sys_time_ns  = r3_q.sys_time_ns;
    conv_o.base_time_ns = is_mono ? '0 : base_time_q;
    conv_o.delta_ns     = delta;
    conv_o.micro        = (r3_q.kind == KIND_RT_US);
  end

  // Control: valid chain, base state, reload history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q  <= 1'b0;
      r2_valid_q  <= 1'b0;
      r3_valid_q  <= 1'b0;
      rs1_q       <= 1'b0;
      rs2_q       <= 1'b0;
      base_cyc_q  <= '0;
      base_time_q <= '0;
    end else if (en_i) begin
      r1_valid_q <= in_valid_i;
      r2_valid_q <= r1_valid_q;
      r3_valid_q <= r2_valid_q;
      rs1_q      <= resync;
      rs2_q      <= rs1_q;
      if (resync) begin
        base_cyc_q  <= r3_q.cycle_count;
        base_time_q <= {1'b0, r3_q.sys_time_ns};
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q <= in_item_i;
      r2_q <= r1_q;
      r3_q <= r2_q;
      for (int i = 0; i < NumCand; i++) begin
        diff_q[i] <= diff_d[i];
        ph_q[i]   <= ph_d[i];
        pl_q[i]   <= pl_d[i];
      end
    end
  end

endmodule

/* hdl/tsc_split.sv */
// tsc_split: final time sum, split into seconds and sub-second, and the result register.
// Division by 1e9 by reciprocal multiply with one correction step; division by 1000 by exact reciprocal multiply.
// Depends on tsc_pkg.

module tsc_split (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             conv_valid_i,
  input  tsc_pkg::conv_t   conv_i,
  output logic             res_valid_o,
  output tsc_pkg::result_t res_o
);
  import tsc_pkg::*;

  localparam int unsigned XW    = TimeW - SecPreShift;      // shifted time width
  localparam int unsigned XHW   = XW - RegW;                // upper slice of it
  localparam int unsigned RHW   = SecW - RegW;              // upper slice of reciprocal
  localparam int unsigned ProdW = XW + SecW;
  localparam int unsigned RemW  = SubW + 1;                 // remainder below 2e9
  localparam int unsigned UsW   = SubW - UsPreShift + UsRecipW;

  localparam logic [RegW-1:0] RecipLo = SecRecip[RegW-1:0];
  localparam logic [RHW-1:0]  RecipHi = SecRecip[SecW-1:RegW];

  // Valid chain, one bit per stage
  logic [7:0]              v_q;
  // Stage A
  conv_t                   a_q;
  // Stage B
  logic [TimeW-1:0]        t_d, t_q;
  logic                    b_micro_q, b_res_q;
  // Stage C
  logic [XW-1:0]           x;
  logic [63:0]             p_ll_d, p_ll_q;
  logic [XHW+RegW-1:0]     p_hl_d, p_hl_q;
  logic [RegW+RHW-1:0]     p_lh_d, p_lh_q;
  logic [XHW+RHW-1:0]      p_hh_d, p_hh_q;
  logic [RemW-1:0]         c_t_q;
  logic                    c_micro_q, c_res_q;
  // Stage D
  logic [ProdW-1:0]        sum;
  logic [SecW-1:0]         d_sec_q;
  logic [RemW-1:0]         d_t_q;
  logic                    d_micro_q, d_res_q;
  // Stage E
  logic [RemW-1:0]         qm_d, qm_q;
  logic [SecW-1:0]         e_sec_q;
  logic [RemW-1:0]         e_t_q;
  logic                    e_micro_q, e_res_q;
  // Stage F
  logic [RemW-1:0]         r_d, r_q;
  logic [SecW-1:0]         f_sec_q;
  logic                    f_micro_q, f_res_q;
  // Stage G
  logic [SecW-1:0]         sec_d, g_sec_q;
  logic [SubW-1:0]         ns_d, g_ns_q;
  logic                    g_micro_q, g_res_q;
  // Result register
  logic [UsW-1:0]          us_prod;
  result_t                 res_d, res_q;

  // Time to report
  assign t_d = a_q.sel_sys ? {1'b0, a_q.sys_time_ns}
                           : (a_q.base_time_ns + a_q.delta_ns);

  // Reciprocal partial products of (t >> 9)
  always_comb begin
    x      = t_q[TimeW-1:SecPreShift];
    p_ll_d = 64'(x[RegW-1:0]) * 64'(RecipLo);
    p_hl_d = (XHW+RegW)'(x[XW-1:RegW]) * (XHW+RegW)'(RecipLo);
    p_lh_d = (RegW+RHW)'(x[RegW-1:0]) * (RegW+RHW)'(RecipHi);
    p_hh_d = (XHW+RHW)'(x[XW-1:RegW]) * (XHW+RHW)'(RecipHi);
  end

  // Seconds estimate, low by at most one
  assign sum = ProdW'(p_ll_q) + (ProdW'(p_hl_q) << RegW) + (ProdW'(p_lh_q) << RegW) +
               (ProdW'(p_hh_q) << (2 * RegW));

  // Low bits of seconds times 1e9 are enough for the remainder
  assign qm_d = d_sec_q[RemW-1:0] * RemW'(NsPerSec);
  assign r_d  = e_t_q - qm_q;

  // Correction step
  always_comb begin
    if (r_q >= RemW'(NsPerSec)) begin
      sec_d = f_sec_q + 1'b1;
      ns_d  = SubW'(r_q - RemW'(NsPerSec));
    end else begin
      sec_d = f_sec_q;
      ns_d  = r_q[SubW-1:0];
    end
  end

  // Microsecond form and result word
  always_comb begin
    us_prod         = UsW'(g_ns_q[SubW-1:UsPreShift]) * UsW'(UsRecip);
    res_d.seconds   = g_sec_q;
    res_d.subsecond = g_micro_q ? SubW'(us_prod >> UsRecipShift) : g_ns_q;
    res_d.resynced  = g_res_q;
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[6:0], conv_valid_i};
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q       <= conv_i;
      t_q       <= t_d;
      b_micro_q <= a_q.micro;
      b_res_q   <= a_q.sel_sys;
      p_ll_q    <= p_ll_d;
      p_hl_q    <= p_hl_d;
      p_lh_q    <= p_lh_d;
      p_hh_q    <= p_hh_d;
      c_t_q     <= t_q[RemW-1:0];
      c_micro_q <= b_micro_q;
      c_res_q   <= b_res_q;
      d_sec_q   <= sum[ProdW-1:SecRecipShift];
      d_t_q     <= c_t_q;
      d_micro_q <= c_micro_q;
      d_res_q   <= c_res_q;
      qm_q      <= qm_d;
      e_sec_q   <= d_sec_q;
      e_t_q     <= d_t_q;
      e_micro_q <= d_micro_q;
      e_res_q   <= d_res_q;
      r_q       <= r_d;
      f_sec_q   <= e_sec_q;
      f_micro_q <= e_micro_q;
      f_res_q   <= e_res_q;
      g_sec_q   <= sec_d;
      g_ns_q    <= ns_d;
      g_micro_q <= f_micro_q;
      g_res_q   <= f_res_q;
      res_q     <= res_d;
    end
  end

  assign res_valid_o = v_q[7];
  assign res_o       = res_q;

endmodule

/* hdl/tsc_timestamp_clock.sv */
// tsc_timestamp_clock: top level of the cycle-counter timestamp clock.
// Instantiates tsc_base_conv and tsc_split; holds the APB registers.
// Depends on tsc_pkg, tsc_in_if and tsc_out_if.

// Takes one query word per clock and returns one result word per query, in order.
// The pipeline is eleven registers deep from the input register to the result
// register. A full result register that is not taken holds the whole pipeline,
// and the input is then not ready. The loop that reloads the base on sync or
// resync spans three stages; the block keeps pace by converting each query
// against the committed base and against both queries ahead of it, then picking
// the right one once their reload decisions are known. Registers: cycle_scale at
// 0x0, resync_ns at 0x4; the user must write them only while no query is in
// flight, the block itself does not enforce it. No clearing pass after reset.
module tsc_timestamp_clock (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsc_in_if.sink      in_i,
  tsc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tsc_pkg::*;

  typedef enum logic {
    REG_CYCLE_SCALE = 1'b0,
    REG_RESYNC_NS   = 1'b1
  } reg_e;

  logic [RegW-1:0] cycle_scale_q;
  logic [RegW-1:0] resync_ns_q;
  logic            cfg_wr;
  reg_e            cfg_sel;

  logic            en;
  item_t           in_item;
  logic            conv_valid;
  conv_t           conv;
  logic            res_valid;
  result_t         res;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_scale_q <= ScaleReset;
      resync_ns_q   <= ResyncReset;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_CYCLE_SCALE: cycle_scale_q <= pwdata;
        REG_RESYNC_NS:   resync_ns_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_CYCLE_SCALE: prdata = cycle_scale_q;
      REG_RESYNC_NS:   prdata = resync_ns_q;
      default:         prdata = '0;
    endcase
  end

  // Whole pipeline advances unless a result waits
  assign en        = !res_valid || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    in_item.kind        = in_i.kind;
    in_item.cycle_count = in_i.cycle_count;
    in_item.sys_time_ns = in_i.sys_time_ns;
  end

  tsc_base_conv u_convert (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .in_valid_i    (in_i.valid),
    .in_item_i     (in_item),
    .cycle_scale_i (cycle_scale_q),
    .resync_ns_i   (resync_ns_q),
    .conv_valid_o  (conv_valid),
    .conv_o        (conv)
  );

  tsc_split u_split (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .conv_valid_i (conv_valid),
    .conv_i       (conv),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result word
  assign out_o.valid     = res_valid;
  assign out_o.seconds   = res.seconds;
  assign out_o.subsecond = res.subsecond;
  assign out_o.resynced  = res.resynced;

endmodule

/* bench/tsc_checker.sv */
// tsc_checker: watches the query, result and register ports of tsc_timestamp_clock,
// predicts every timestamp word and compares the results in order.
// Depends on tsc_pkg, tsc_in_if and tsc_out_if.

module tsc_checker #(
  parameter logic [2:0] ScaleAddr  = 3'd0,
  parameter logic [2:0] ResyncAddr = 3'd4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsc_in_if           query_i,
  tsc_out_if          result_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  input  logic        pready_i,
  output int          errors_o,
  output int          pending_o
);
  import tsc_pkg::*;

  localparam logic [63:0] NsPerSecond = 64'd1000000000;
  localparam logic [63:0] NsPerMicro  = 64'd1000;

  // Shadow registers and the clock base
  logic [RegW-1:0] scale;
  logic [RegW-1:0] threshold;
  logic [63:0]     base_cycles;
  logic [63:0]     base_ns;

  result_t stamps_due[$];
  int      errors = 0;

  assign errors_o = errors;

  // Fixed-point cycles to nanoseconds, wrapping mod 2^64
  function automatic logic [63:0] cycles_ns(input logic [63:0] cyc);
    logic [63:0] hi_prod;
    logic [63:0] lo_prod;
    hi_prod = {32'd0, cyc[63:32]} * {32'd0, scale};
    lo_prod = {32'd0, cyc[31:0]} * {32'd0, scale};
    return (hi_prod << ScaleShift) + (lo_prod >> LoShift);
  endfunction

  // Seconds plus sub-second part, in us when asked
  function automatic result_t split_time(input logic [63:0] t, input logic micro,
                                         input logic reloaded);
    result_t     r;
    logic [63:0] secs;
    logic [63:0] frac;
    secs = t / NsPerSecond;
    frac = t % NsPerSecond;
    if (micro) begin
      frac = frac / NsPerMicro;
    end
    r.seconds   = secs[SecW-1:0];
    r.subsecond = frac[SubW-1:0];
    r.resynced  = reloaded;
    return r;
  endfunction

  // Timestamp for one query; sync or a large delta reloads the base
  function automatic result_t timestamp(input kind_e kind, input logic [63:0] cyc,
                                        input logic [62:0] sys);
    logic [63:0] delta;
    if (kind == KIND_MONO) begin
      return split_time(cycles_ns(cyc), 1'b0, 1'b0);
    end
    delta = cycles_ns(cyc - base_cycles);
    if (kind == KIND_SYNC || delta >= {32'd0, threshold}) begin
      base_cycles = cyc;
      base_ns     = {1'b0, sys};
      return split_time({1'b0, sys}, kind == KIND_RT_US, 1'b1);
    end
    return split_time(base_ns + delta, kind == KIND_RT_US, 1'b0);
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      scale       = ScaleReset;
      threshold   = ResyncReset;
      base_cycles = '0;
      base_ns     = '0;
      stamps_due.delete();
      pending_o  <= 0;
    end else begin
      // Register port: track writes, check reads
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i)
            ScaleAddr:  scale = pwdata_i;
            ResyncAddr: threshold = pwdata_i;
            default: ;
          endcase
        end else begin
          case (paddr_i)
            ScaleAddr:  check_field("cycle_scale read", 64'(scale), 64'(prdata_i));
            ResyncAddr: check_field("resync_ns read", 64'(threshold), 64'(prdata_i));
            default: ;
          endcase
        end
      end

      if (query_i.valid && query_i.ready) begin
        stamps_due.push_back(timestamp(query_i.kind, query_i.cycle_count,
                                       query_i.sys_time_ns));
      end

      // Results must come back in query order
      if (result_i.valid && result_i.ready) begin
        if (stamps_due.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected: seconds %0d subsecond %0d",
                   $time, result_i.seconds, result_i.subsecond);
        end else begin
          want = stamps_due.pop_front();
          check_field("seconds", 64'(want.seconds), 64'(result_i.seconds));
          check_field("subsecond", 64'(want.subsecond), 64'(result_i.subsecond));
          check_field("resynced", 64'(want.resynced), 64'(result_i.resynced));
        end
      end

      pending_o <= stamps_due.size();
    end
  end

endmodule

/* bench/tsc_timestamp_clock_test.sv */
// tsc_timestamp_clock_test: drives queries, register writes and output stalls
// into tsc_timestamp_clock; tsc_checker predicts and compares the results.
// Depends on tsc_pkg, tsc_in_if, tsc_out_if, tsc_checker and the block itself.

module tsc_timestamp_clock_test;
  import tsc_pkg::*;

  localparam logic [2:0] ScaleAddr    = 3'd0;
  localparam logic [2:0] ResyncAddr   = 3'd4;
  localparam int         QuietLimit   = 2000;
  localparam int         SettleCycles = 16;
  localparam int         PhaseWords   = 220;
  localparam logic [62:0] SysMax      = 63'h7FFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          quiet = 0;

  // Stimulus state
  logic [63:0] cur_cyc;
  logic [62:0] cur_sys;
  logic [31:0] cfg_scale;
  logic [31:0] cfg_resync;
  bit          gaps_on;
  bit          stalls_on;

  tsc_in_if  query_w ();
  tsc_out_if result_w ();

  tsc_timestamp_clock DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (query_w),
    .out_o   (result_w),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tsc_checker #(
    .ScaleAddr  (ScaleAddr),
    .ResyncAddr (ResyncAddr)
  ) ts_check (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .query_i   (query_w),
    .result_i  (result_w),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_i  (prdata),
    .pready_i  (pready),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One query word; optional gap before it, then hold until taken
  task automatic send_query(input kind_e kind, input logic [63:0] cyc,
                            input logic [62:0] sys);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      query_w.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query_w.valid       <= 1'b1;
    query_w.kind        <= kind;
    query_w.cycle_count <= cyc;
    query_w.sys_time_ns <= sys;
    do @(posedge clk); while (!query_w.ready);
  endtask

  // Stop sending and wait until every result word is back
  task automatic drain();
    query_w.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic [2:0] addr, input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Only called with the pipeline empty
  task automatic configure(input logic [31:0] scale, input logic [31:0] resync);
    apb_access(ScaleAddr, 1'b1, scale);
    apb_access(ResyncAddr, 1'b1, resync);
    apb_access(ScaleAddr, 1'b0, '0);
    apb_access(ResyncAddr, 1'b0, '0);
    psel       <= 1'b0;
    penable    <= 1'b0;
    cfg_scale   = scale;
    cfg_resync  = resync;
  endtask

  // Mostly sync followed by a burst of reads near the resync point; some noise
  task automatic run_phase(input int count);
    int          sent;
    int          burst;
    bit          paused;
    logic [63:0] reach;
    logic [63:0] step;
    kind_e       kind;
    sent   = 0;
    paused = 0;
    // cycles that roughly make up one resync interval
    reach = (cfg_scale == 0) ? (64'd1 << 40)
                             : ({32'd0, cfg_resync} << 27) / {32'd0, cfg_scale};
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        send_query(kind_e'($urandom_range(0, 3)), {$urandom, $urandom},
                   63'({$urandom, $urandom}));
        sent++;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          cur_cyc = {$urandom, $urandom};
          cur_sys = 63'({$urandom, $urandom});
        end else begin
          cur_cyc = cur_cyc + $urandom_range(0, 1000);
          cur_sys = cur_sys + $urandom;
        end
        send_query(KIND_SYNC, cur_cyc, cur_sys);
        sent++;
        burst = $urandom_range(2, 10);
        repeat (burst) begin
          if ($urandom_range(0, 99) < 5) begin
            cur_cyc = cur_cyc - $urandom_range(1, 100);
          end else begin
            step    = (reach >> 6) * $urandom_range(0, 96) + $urandom_range(0, 3);
            cur_cyc = cur_cyc + step;
          end
          cur_sys = cur_sys + $urandom_range(0, 2000000);
          if ($urandom_range(0, 9) == 0) begin
            kind = KIND_MONO;
          end else begin
            kind = $urandom_range(0, 1) ? KIND_RT_US : KIND_RT_NS;
          end
          send_query(kind, cur_cyc, cur_sys);
          sent++;
        end
      end
      // let the pipeline run dry once mid-phase
      if (!paused && sent >= count / 2) begin
        drain();
        paused = 1;
      end
    end
    drain();
  endtask

  // Receiver: random stall before each result word
  initial begin
    int stall;
    result_w.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = stalls_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        result_w.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_w.ready <= 1'b1;
      do @(posedge clk); while (!result_w.valid);
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if ((query_w.valid && query_w.ready) || (result_w.valid && result_w.ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QuietLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    query_w.valid       = 1'b0;
    query_w.kind        = KIND_SYNC;
    query_w.cycle_count = '0;
    query_w.sys_time_ns = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cfg_scale           = ScaleReset;
    cfg_resync          = ResyncReset;
    cur_cyc             = '0;
    cur_sys             = '0;
    gaps_on             = 1'b1;
    stalls_on           = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one cycle is one ns, resync after 1 ms
    send_query(KIND_RT_NS, 64'd100, 63'd0);          // read against the zero base
    send_query(KIND_SYNC, 64'd0, 63'd0);
    send_query(KIND_RT_US, 64'd999999, 63'd123);      // just under the threshold
    send_query(KIND_RT_NS, 64'd1000000, 63'd5);       // delta equal to threshold
    send_query(KIND_SYNC, '1, SysMax);
    send_query(KIND_RT_NS, 64'd499, 63'd0);           // counter wrapped past zero
    send_query(KIND_RT_US, 64'd999, 63'd0);
    send_query(KIND_RT_NS, 64'hFFFF_FFFF_FFFF_FFF0, 63'd42);  // counter behind base
    send_query(KIND_MONO, 64'd0, SysMax);
    send_query(KIND_MONO, '1, 63'd0);
    send_query(KIND_MONO, 64'h0000_0001_0000_0000, 63'd7);
    send_query(KIND_SYNC, 64'd1000, 63'd999999999);
    send_query(KIND_RT_US, 64'd1000, 63'd0);
    send_query(KIND_SYNC, 64'd0, 63'd1000000000);
    send_query(KIND_RT_NS, 64'd999999, 63'd0);
    send_query(KIND_RT_US, 64'd999999, 63'd0);
    drain();

    run_phase(PhaseWords);

    // Largest scale and threshold, no idling on either side
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_query(KIND_MONO, '1, 63'd0);
    run_phase(PhaseWords);

    // Smallest legal settings
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    configure(32'd1, 32'd1);
    run_phase(PhaseWords);

    // Zero scale: conversion gives zero; zero threshold: every real-time read reloads
    configure(32'd0, 32'd0);
    send_query(KIND_SYNC, 64'd77, 63'd123456789012);
    send_query(KIND_RT_NS, 64'd5000, 63'd1);
    send_query(KIND_RT_US, '1, 63'd2);
    send_query(KIND_MONO, '1, 63'd3);
    drain();
    configure(32'd0, 32'd1000000);
    send_query(KIND_SYNC, 64'd77, 63'd123456789012);
    send_query(KIND_RT_NS, '1, 63'd1);
    send_query(KIND_RT_US, 64'd12345, 63'd2);
    drain();
    run_phase(50);

    // Realistic frequencies, then anything
    for (int p = 0; p < 4; p++) begin
      gaps_on   = p[0];
      stalls_on = 1'($urandom_range(0, 1));
      if (p == 3) begin
        configure($urandom, $urandom);
      end else begin
        configure($urandom_range(32'h0200_0000, 32'h2000_0000),
                  $urandom_range(1000, 4000000));
      end
      run_phase(PhaseWords);
    end

    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/tsc_pkg.sv
hdl/tsc_in_if.sv
hdl/tsc_out_if.sv
hdl/tsc_convert.sv
hdl/tsc_split.sv
hdl/tsc_timestamp_clock.sv
bench/tsc_checker.sv
bench/tsc_timestamp_clock_test.sv
